// ===== rtl/core/spb_pkg.sv =====
// Shared types and constants for the skeletal pose blend block.
package spb_pkg;

	localparam int ELEMS = 12;
	localparam logic [3:0] LAST_ELEM = 4'd11;
	localparam logic [1:0] TRANS_COL = 2'd3;

	typedef struct packed {
		logic               has_parent;
		logic [6:0]         parent_index;
		logic [63:0]        curr_rotation;
		logic [63:0]        next_rotation;
		logic signed [31:0] curr_pos_x;
		logic signed [31:0] curr_pos_y;
		logic signed [31:0] curr_pos_z;
		logic signed [31:0] next_pos_x;
		logic signed [31:0] next_pos_y;
		logic signed [31:0] next_pos_z;
		logic               last_bone;
	} spb_in_t;

	typedef struct packed {
		logic [6:0]         bone_number;
		logic [1:0]         row;
		logic [1:0]         column;
		logic signed [31:0] element_value;
		logic               last_element;
	} spb_out_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BLEND_Q,
		OP_BLEND_P,
		OP_QPROD,
		OP_PMAC
	} spb_op_t;

	typedef struct packed {
		logic       capture;
		spb_op_t    op;
		logic [3:0] idx;
		logic       rd_en;
		logic [3:0] rd_word;
		logic       loc_latch;
		logic       emit;
		logic [3:0] elem;
		logic [1:0] k;
	} spb_cmd_t;

	typedef struct packed {
		logic use_par;
		logic out_free;
	} spb_stat_t;

endpackage

// ===== rtl/core/skeletal_pose_blend.sv =====
// Top level of the skeletal pose blend block: sequencer plus datapath.
//
//  channel | signals                    | beat
//  --------+----------------------------+-------------------------------
//  in      | in_valid in_ready in_data  | one bone
//  out     | out_valid out_ready out_data | one transform element
//  cfg     | cfg_wr_en cfg_wr_data      | blend factor write
//
// A bone is captured, blended over the PREP steps and its local matrix latched,
// then its 12 element slots are emitted; with a parent each slot first runs its
// MAC and WAIT states, as all 36 parent products share one 33x33 multiplier.
// Reset clears the bone counter, factor and per-bone valid bits; no sweep.
// A stalled output holds the sequencer at the element being emitted.
module skeletal_pose_blend #(
	parameter int MAX_BONES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spb_pkg::spb_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output spb_pkg::spb_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data
);
	import spb_pkg::*;

	spb_cmd_t  cmd;
	spb_stat_t stat;

	spb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spb_dp #(.MAX_BONES(MAX_BONES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

// ===== rtl/core/spb_ctrl.sv =====
// Sequencer for the pose blend datapath: prepare, latch local transform, emit elements.
module spb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  spb_pkg::spb_stat_t stat,
	output spb_pkg::spb_cmd_t  cmd
);
	import spb_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_LOC, S_MAC, S_WAIT, S_EMIT} state_t;

	localparam logic [4:0] PREP_LAST = 5'd16;

	state_t     state_q;
	logic [4:0] step_q;
	logic [3:0] elem_q;
	logic [1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			elem_q  <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
						step_q  <= '0;
					end
				end
				S_PREP: begin
					if (step_q == PREP_LAST) state_q <= S_LOC;
					else step_q <= step_q + 5'd1;
				end
				S_LOC: begin
					elem_q  <= '0;
					k_q     <= '0;
					state_q <= stat.use_par ? S_MAC : S_EMIT;
				end
				S_MAC: begin
					if (k_q == 2'd2) state_q <= S_WAIT;
					else k_q <= k_q + 2'd1;
				end
				S_WAIT: state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free) begin
						if (elem_q == LAST_ELEM) begin
							state_q <= S_IDLE;
						end else begin
							elem_q  <= elem_q + 4'd1;
							k_q     <= '0;
							state_q <= stat.use_par ? S_MAC : S_EMIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.op        = OP_NONE;
		cmd.elem      = elem_q;
		cmd.k         = k_q;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.loc_latch = (state_q == S_LOC);
		cmd.emit      = (state_q == S_EMIT) && stat.out_free;
		if (state_q == S_PREP) begin
			cmd.rd_en   = (step_q < 5'd12);
			cmd.rd_word = step_q[3:0];
			if (step_q < 5'd4) begin
				cmd.op  = OP_BLEND_Q;
				cmd.idx = step_q[3:0];
			end else if (step_q < 5'd7) begin
				cmd.op  = OP_BLEND_P;
				cmd.idx = 4'(step_q - 5'd4);
			end else if (step_q < PREP_LAST) begin
				cmd.op  = OP_QPROD;
				cmd.idx = 4'(step_q - 5'd7);
			end
		end else if (state_q == S_MAC) begin
			cmd.op = OP_PMAC;
		end
	end

endmodule

// ===== rtl/core/spb_dp.sv =====
// Datapath: blend, quaternion to matrix, parent product, transform store and output register.
module spb_dp #(
	parameter int MAX_BONES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spb_pkg::spb_in_t   in_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  spb_pkg::spb_cmd_t  cmd,
	output spb_pkg::spb_stat_t stat,
	input  logic               out_ready,
	output logic               out_valid,
	output spb_pkg::spb_out_t  out_data
);
	import spb_pkg::*;

	localparam int NB    = (MAX_BONES < 128) ? MAX_BONES : 128;
	localparam int DEPTH = NB * ELEMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
	localparam logic [7:0] NB_W = 8'(NB);
	localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

	logic [15:0]        blend_q;
	spb_in_t            item_q;
	logic [6:0]         bone_q;
	logic [6:0]         count_q;
	logic               use_par_q;
	logic [NB-1:0]      valid_q;
	logic signed [15:0] q_q [4];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] prod_q [9];
	logic signed [31:0] loc_q [12];
	logic signed [31:0] p_q [12];
	logic signed [65:0] acc_q;
	logic signed [65:0] mult_s1;
	spb_op_t            op_s1;
	logic [3:0]         idx_s1;
	logic [1:0]         k_s1;
	logic               ld_s1;
	logic [3:0]         ldw_s1;
	logic [31:0]        rd_data_s1;
	logic [31:0]        mem [DEPTH];
	logic               out_valid_q;
	spb_out_t           out_q;

	logic signed [15:0] cq [4];
	logic signed [15:0] nq [4];
	logic signed [31:0] cp_sel;
	logic signed [16:0] dq;
	logic signed [32:0] pdiff;
	logic signed [32:0] ma, mb;
	logic signed [15:0] qa, qb;
	logic signed [65:0] rnd;
	logic signed [31:0] loc_c [12];
	logic signed [65:0] acc_r;
	logic signed [65:0] acc_t;
	logic signed [31:0] elem_val;
	logic [1:0]         e_row, e_col;
	logic [10:0]        waddr_w, raddr_w;
	logic               store_en;
	logic               pvalid;

	function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
		return {{4{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] q28_to_q16(input logic signed [35:0] v);
		logic signed [35:0] t;
		t = (v + 36'sd2048) >>> 12;
		return t[31:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cq[i] = item_q.curr_rotation[63 - 16 * i -: 16];
			nq[i] = item_q.next_rotation[63 - 16 * i -: 16];
		end
	end

	always_comb begin
		case (idx_s1[1:0])
			2'd0:    cp_sel = item_q.curr_pos_x;
			2'd1:    cp_sel = item_q.curr_pos_y;
			default: cp_sel = item_q.curr_pos_z;
		endcase
	end

	// Position difference needs 33 bits when the inputs span the full range
	always_comb begin
		case (cmd.idx[1:0])
			2'd0:    pdiff = 33'(item_q.next_pos_x) - 33'(item_q.curr_pos_x);
			2'd1:    pdiff = 33'(item_q.next_pos_y) - 33'(item_q.curr_pos_y);
			default: pdiff = 33'(item_q.next_pos_z) - 33'(item_q.curr_pos_z);
		endcase
	end

	// Quaternion products: yy zz xx xy wz xz wy yz wx
	always_comb begin
		case (cmd.idx)
			4'd0:    begin qa = q_q[2]; qb = q_q[2]; end
			4'd1:    begin qa = q_q[3]; qb = q_q[3]; end
			4'd2:    begin qa = q_q[1]; qb = q_q[1]; end
			4'd3:    begin qa = q_q[1]; qb = q_q[2]; end
			4'd4:    begin qa = q_q[0]; qb = q_q[3]; end
			4'd5:    begin qa = q_q[1]; qb = q_q[3]; end
			4'd6:    begin qa = q_q[0]; qb = q_q[2]; end
			4'd7:    begin qa = q_q[2]; qb = q_q[3]; end
			default: begin qa = q_q[0]; qb = q_q[1]; end
		endcase
	end

	always_comb begin
		dq = {nq[cmd.idx[1:0]][15], nq[cmd.idx[1:0]]}
			- {cq[cmd.idx[1:0]][15], cq[cmd.idx[1:0]]};
		case (cmd.op)
			OP_BLEND_Q: begin
				ma = {{16{dq[16]}}, dq};
				mb = {17'b0, blend_q};
			end
			OP_BLEND_P: begin
				ma = pdiff;
				mb = {17'b0, blend_q};
			end
			OP_QPROD: begin
				ma = {{17{qa[15]}}, qa};
				mb = {{17{qb[15]}}, qb};
			end
			OP_PMAC: begin
				ma = {loc_q[{cmd.k, cmd.elem[1:0]}][31], loc_q[{cmd.k, cmd.elem[1:0]}]};
				mb = {p_q[{cmd.elem[3:2], cmd.k}][31], p_q[{cmd.elem[3:2], cmd.k}]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign rnd = (mult_s1 + 66'sd32768) >>> 16;

	always_comb begin
		loc_c[0]  = q28_to_q16(ONE_Q28 - ((sx36(prod_q[0]) + sx36(prod_q[1])) <<< 1));
		loc_c[1]  = q28_to_q16((sx36(prod_q[3]) - sx36(prod_q[4])) <<< 1);
		loc_c[2]  = q28_to_q16((sx36(prod_q[5]) + sx36(prod_q[6])) <<< 1);
		loc_c[3]  = pos_q[0];
		loc_c[4]  = q28_to_q16((sx36(prod_q[3]) + sx36(prod_q[4])) <<< 1);
		loc_c[5]  = q28_to_q16(ONE_Q28 - ((sx36(prod_q[2]) + sx36(prod_q[1])) <<< 1));
		loc_c[6]  = q28_to_q16((sx36(prod_q[7]) - sx36(prod_q[8])) <<< 1);
		loc_c[7]  = pos_q[1];
		loc_c[8]  = q28_to_q16((sx36(prod_q[5]) - sx36(prod_q[6])) <<< 1);
		loc_c[9]  = q28_to_q16((sx36(prod_q[7]) + sx36(prod_q[8])) <<< 1);
		loc_c[10] = q28_to_q16(ONE_Q28 - ((sx36(prod_q[2]) + sx36(prod_q[0])) <<< 1));
		loc_c[11] = pos_q[2];
	end

	assign e_row = cmd.elem[3:2];
	assign e_col = cmd.elem[1:0];

	always_comb begin
		acc_r = (acc_q + 66'sd32768) >>> 16;
		acc_t = acc_r;
		if (e_col == TRANS_COL) acc_t = acc_r + 66'(p_q[{e_row, TRANS_COL}]);
		if (acc_t > 66'sd2147483647) elem_val = 32'sh7FFFFFFF;
		else if (acc_t < -66'sd2147483648) elem_val = 32'sh80000000;
		else elem_val = acc_t[31:0];
		if (!use_par_q) elem_val = loc_q[cmd.elem];
	end

	assign waddr_w  = 11'({4'b0, bone_q} * 11'd12) + {7'b0, cmd.elem};
	assign raddr_w  = 11'({4'b0, item_q.parent_index} * 11'd12) + {7'b0, cmd.rd_word};
	assign store_en = ({1'b0, bone_q} < NB_W);
	assign pvalid   = use_par_q && valid_q[item_q.parent_index[BW-1:0]];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q     <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			op_s1       <= OP_NONE;
			ld_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) blend_q <= cfg_wr_data;
			if (cmd.capture) count_q <= in_data.last_bone ? 7'd0 : count_q + 7'd1;
			if (cmd.emit && store_en) valid_q[bone_q[BW-1:0]] <= 1'b1;
			op_s1 <= cmd.op;
			ld_s1 <= cmd.rd_en;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q    <= in_data;
			bone_q    <= count_q;
			use_par_q <= in_data.has_parent && ({1'b0, in_data.parent_index} < NB_W);
		end
		mult_s1 <= 66'(ma) * 66'(mb);
		idx_s1  <= cmd.idx;
		k_s1    <= cmd.k;
		ldw_s1  <= cmd.rd_word;
		case (op_s1)
			OP_BLEND_Q: q_q[idx_s1[1:0]] <= cq[idx_s1[1:0]] + rnd[15:0];
			OP_BLEND_P: begin
				case (idx_s1[1:0])
					2'd0:    pos_q[0] <= cp_sel + rnd[31:0];
					2'd1:    pos_q[1] <= cp_sel + rnd[31:0];
					default: pos_q[2] <= cp_sel + rnd[31:0];
				endcase
			end
			OP_QPROD: prod_q[idx_s1] <= mult_s1[31:0];
			OP_PMAC:  acc_q <= (k_s1 == 2'd0) ? mult_s1 : acc_q + mult_s1;
			default: ;
		endcase
		if (ld_s1) p_q[ldw_s1] <= pvalid ? rd_data_s1 : 32'd0;
		if (cmd.loc_latch) loc_q <= loc_c;
		if (cmd.emit) begin
			out_q.bone_number   <= bone_q;
			out_q.row           <= e_row;
			out_q.column        <= e_col;
			out_q.element_value <= elem_val;
			out_q.last_element  <= (cmd.elem == LAST_ELEM);
		end
	end

	// Transform store: written one element per emit, read one word per cycle while rd_en is set
	always_ff @(posedge clk) begin
		if (cmd.emit && store_en) mem[AW'(waddr_w)] <= elem_val;
		if (cmd.rd_en) rd_data_s1 <= mem[AW'(raddr_w)];
	end

	assign stat.use_par  = use_par_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

// ===== rtl/core/spb_checker.sv =====
// Port-level checks for the skeletal pose blend block, bound to the top level.
module spb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input spb_pkg::spb_out_t out_data
);
	import spb_pkg::*;

	// Hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// One bone at a time: drop ready after an accepted beat
	a_one_bone: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second bone accepted while busy");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_element == (out_data.row == 2'd2 &&
			out_data.column == TRANS_COL)))
		else $error("last element flag out of place");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.row != 2'd3)
		else $error("row out of range");

endmodule

bind skeletal_pose_blend spb_checker u_spb_checker (.*);

// ===== verif/skeletal_pose_blend_tb.sv =====
// Self-checking testbench for the skeletal pose blend block.
module skeletal_pose_blend_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spb_pkg::*;

	localparam int N_BONES = 128;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	spb_in_t in_data;
	logic out_valid;
	logic out_ready;
	spb_out_t out_data;
	logic cfg_wr_en;
	logic [15:0] cfg_wr_data;

	skeletal_pose_blend uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// predictor state
	logic [15:0] factor;
	int xform [N_BONES*ELEMS];
	logic [6:0] bone_ctr;

	spb_in_t pose_q[$];
	spb_out_t expected_elems[$];
	int fails;
	int bones_sent;
	int elems_seen;
	longint cycles;
	int gap_cnt;
	int stall_cnt;
	bit send_burst;
	bit recv_burst;

	function automatic longint mix(longint c, longint n);
		return (c * (65536 - longint'(factor)) + n * longint'(factor) + 32768) >>> 16;
	endfunction

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic int q28_to_q16(longint v);
		return sat32((v + 2048) >>> 12);
	endfunction

	// Blend one bone, chain it to its parent, store it and queue its 12 elements.
	function automatic void blend_bone(spb_in_t b);
		longint q[4];
		longint p[3];
		longint w, x, y, z, one, hi, lo, v, prod;
		int loc[ELEMS];
		int res[ELEMS];
		int base;
		spb_out_t e;
		one = longint'(1) << 28;
		for (int i = 0; i < 4; i++) begin
			q[i] = mix(longint'($signed(b.curr_rotation[48-16*i +: 16])),
				longint'($signed(b.next_rotation[48-16*i +: 16])));
		end
		p[0] = mix(b.curr_pos_x, b.next_pos_x);
		p[1] = mix(b.curr_pos_y, b.next_pos_y);
		p[2] = mix(b.curr_pos_z, b.next_pos_z);
		w = q[0]; x = q[1]; y = q[2]; z = q[3];
		loc[0]  = q28_to_q16(one - 2 * (y*y + z*z));
		loc[1]  = q28_to_q16(2 * (x*y - w*z));
		loc[2]  = q28_to_q16(2 * (x*z + w*y));
		loc[4]  = q28_to_q16(2 * (x*y + w*z));
		loc[5]  = q28_to_q16(one - 2 * (x*x + z*z));
		loc[6]  = q28_to_q16(2 * (y*z - w*x));
		loc[8]  = q28_to_q16(2 * (x*z - w*y));
		loc[9]  = q28_to_q16(2 * (y*z + w*x));
		loc[10] = q28_to_q16(one - 2 * (x*x + y*y));
		loc[3]  = int'(p[0]);
		loc[7]  = int'(p[1]);
		loc[11] = int'(p[2]);
		if (b.has_parent && b.parent_index < N_BONES) begin
			base = b.parent_index * ELEMS;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					hi = 0;
					lo = 0;
					for (int k = 0; k < 3; k++) begin
						prod = longint'(xform[base + r*4 + k]) * longint'(loc[k*4 + c]);
						hi += prod >>> 16;
						lo += prod & 64'hFFFF;
					end
					v = hi + ((lo + 32768) >>> 16);
					if (c == TRANS_COL) v += longint'(xform[base + r*4 + 3]);
					res[r*4 + c] = sat32(v);
				end
			end
		end else begin
			res = loc;
		end
		for (int i = 0; i < ELEMS; i++) begin
			xform[bone_ctr*ELEMS + i] = res[i];
			e.bone_number = bone_ctr;
			e.row = 2'(i / 4);
			e.column = 2'(i % 4);
			e.element_value = res[i];
			e.last_element = (i == LAST_ELEM);
			expected_elems.insert(expected_elems.size(), e);
		end
		bone_ctr = b.last_bone ? 7'd0 : bone_ctr + 7'd1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		fails++;
		$display("mismatch %s: got %0d, want %0d (element %0d)", what, got, want, elems_seen);
	endtask

	function automatic logic [63:0] rand_quat();
		logic [63:0] r;
		r = {$urandom, $urandom};
		// mostly keep components within a unit range
		if ($urandom_range(0, 3) != 0) begin
			for (int i = 0; i < 4; i++)
				r[16*i +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_pos();
		if ($urandom_range(0, 2) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 2**22)) - 2**21);
	endfunction

	function automatic spb_in_t make_bone(logic hp, logic [6:0] par, logic last);
		spb_in_t b;
		b.has_parent = hp;
		b.parent_index = par;
		b.curr_rotation = rand_quat();
		b.next_rotation = rand_quat();
		b.curr_pos_x = rand_pos();
		b.curr_pos_y = rand_pos();
		b.curr_pos_z = rand_pos();
		b.next_pos_x = rand_pos();
		b.next_pos_y = rand_pos();
		b.next_pos_z = rand_pos();
		b.last_bone = last;
		return b;
	endfunction

	// a pose; if wellformed, bone 0 is root and the rest name earlier parents
	task automatic queue_pose(int n, bit wellformed);
		spb_in_t b;
		for (int i = 0; i < n; i++) begin
			if (wellformed)
				b = make_bone(i != 0, 7'(i == 0 ? 0 : $urandom_range(0, i - 1)), i == n - 1);
			else
				b = make_bone(1'($urandom_range(0, 1)), 7'($urandom),
					$urandom_range(0, 7) == 0);
			pose_q.insert(pose_q.size(), b);
			bones_sent++;
		end
	endtask

	task automatic wait_idle();
		while (pose_q.size() != 0 || in_valid || expected_elems.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_factor(logic [15:0] f);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= f;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		factor = f;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: present pending bones with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				blend_bone(in_data);
			if (!in_valid || in_ready) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					in_valid <= 1'b0;
				end else if (pose_q.size() != 0) begin
					in_data <= pose_q.pop_front();
					in_valid <= 1'b1;
					if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
					gap_cnt = send_burst ? 0 : $urandom_range(0, 18);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each element beat with the oldest expectation
	always @(posedge clk) begin
		spb_out_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_elems.size() == 0) begin
					report_mismatch("unexpected beat, bone_number", out_data.bone_number, -1);
				end else begin
					want = expected_elems.pop_front();
					if (out_data.bone_number !== want.bone_number)
						report_mismatch("bone_number", out_data.bone_number, want.bone_number);
					if (out_data.row !== want.row)
						report_mismatch("row", out_data.row, want.row);
					if (out_data.column !== want.column)
						report_mismatch("column", out_data.column, want.column);
					if (out_data.element_value !== want.element_value)
						report_mismatch("element_value", out_data.element_value,
							want.element_value);
					if (out_data.last_element !== want.last_element)
						report_mismatch("last_element", out_data.last_element,
							want.last_element);
				end
				elems_seen++;
				if ($urandom_range(0, 60) == 0) recv_burst = !recv_burst;
				stall_cnt = recv_burst ? 0 : $urandom_range(0, 18);
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		spb_in_t b;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		factor = '0;
		bone_ctr = '0;
		foreach (xform[i]) xform[i] = 0;
		fails = 0;
		bones_sent = 0;
		elems_seen = 0;
		cycles = 0;
		gap_cnt = 0;
		stall_cnt = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, chaining, self parent, unwritten parent
		write_factor(16'd0);
		pose_q.insert(pose_q.size(), '0);
		b = '0;
		b.curr_rotation = {4{16'h7FFF}};
		b.next_rotation = {4{16'h8000}};
		b.curr_pos_x = 32'h7FFFFFFF; b.curr_pos_y = 32'h80000000; b.curr_pos_z = 32'h7FFFFFFF;
		b.next_pos_x = 32'h80000000; b.next_pos_y = 32'h7FFFFFFF; b.next_pos_z = 32'h80000000;
		pose_q.insert(pose_q.size(), b);
		b.curr_rotation = {4{16'h8000}};
		b.has_parent = 1'b1;
		b.parent_index = 7'd1;
		pose_q.insert(pose_q.size(), b);
		pose_q.insert(pose_q.size(), make_bone(1'b1, 7'd3, 1'b0));
		pose_q.insert(pose_q.size(), make_bone(1'b1, 7'd100, 1'b0));
		pose_q.insert(pose_q.size(), make_bone(1'b1, 7'd127, 1'b0));
		pose_q.insert(pose_q.size(), make_bone(1'b1, 7'd0, 1'b1));
		bones_sent += 7;
		wait_idle();
		write_factor(16'hFFFF);
		pose_q.insert(pose_q.size(), b);
		b.has_parent = 1'b0;
		b.next_rotation = {16'h4000, 16'h0, 16'h0, 16'h0};
		pose_q.insert(pose_q.size(), b);
		bones_sent += 2;
		queue_pose(6, 1'b1);
		wait_idle();
		write_factor(16'h8000);
		queue_pose(8, 1'b1);
		queue_pose(4, 1'b0);
		wait_idle();

		// random: mostly well-formed poses, some noise, one counter wrap
		while (bones_sent < 450) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				write_factor($urandom_range(0, 4) == 0 ? 16'hFFFF : 16'($urandom));
			end
			if ($urandom_range(0, 5) == 0)
				queue_pose($urandom_range(1, 6), 1'b0);
			else
				queue_pose($urandom_range(1, 24), 1'b1);
			if (bones_sent > 200 && bones_sent < 230) begin
				repeat (130) begin
					pose_q.insert(pose_q.size(),
						make_bone(1'($urandom_range(0, 1)), 7'($urandom), 1'b0));
					bones_sent++;
				end
			end
			while (pose_q.size() > 8) @(posedge clk);
		end
		wait_idle();

		$display("%0d bones sent, %0d element beats checked, blend factor extremes and",
			bones_sent, elems_seen);
		$display("counter wrap exercised with random gaps and stalls on both sides");
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", fails);
			$display("FAIL");
		end
		$finish;
	end

endmodule
